### rtl/core/frb_pkg.sv
// ----------------------------------------------------------------------------
// frb_pkg
// shared types, constants and the control program of the framed receive
// ring buffer
// ----------------------------------------------------------------------------
package frb_pkg;

  localparam int BufferDepth = 64;
  localparam int MaxPop      = 64;
  localparam int LenW        = 7;

  // read status codes
  typedef enum logic [1:0] {
    ST_REMAIN    = 2'd0,
    ST_NOW_EMPTY = 2'd1,
    ST_WAS_EMPTY = 2'd2
  } rd_status_t;

  // framing tracker phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_COUNT  = 2'd2
  } phase_t;

  // program steps
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_STORE  = 3'd1,
    S_RCHK   = 3'd2,
    S_REMPTY = 3'd3,
    S_RZERO  = 3'd4,
    S_RFIRST = 3'd5,
    S_RLOOP  = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    EM_NONE  = 3'd0,
    EM_STORE = 3'd1,
    EM_EMPTY = 3'd2,
    EM_ZERO  = 3'd3,
    EM_BYTE  = 3'd4
  } emit_t;

  typedef enum logic [1:0] {
    RD_NONE    = 2'd0,
    RD_ALWAYS  = 2'd1,
    RD_IF_MORE = 2'd2
  } rd_op_t;

  typedef enum logic [1:0] {
    J_GOTO     = 2'd0,
    J_DISPATCH = 2'd1,
    J_CHECK    = 2'd2,
    J_LOOP     = 2'd3
  } jmp_t;

  // one control word
  typedef struct packed {
    logic   busy;
    logic   store;
    logic   load_cnt;
    emit_t  emit;
    rd_op_t rd;
    jmp_t   jmp;
    step_t  tgt;
  } ctl_t;

  // conditions seen by the sequencer
  typedef struct packed {
    logic start;
    logic func;
    logic empty;
    logic zlen;
    logic more;
  } cond_t;

  // control store
  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    w = '{busy: 1'b1, store: 1'b0, load_cnt: 1'b0, emit: EM_NONE, rd: RD_NONE,
          jmp: J_GOTO, tgt: S_IDLE};
    case (s)
      S_IDLE: begin
        w.busy = 1'b0;
        w.jmp  = J_DISPATCH;
      end
      S_STORE: begin
        w.store = 1'b1;
        w.emit  = EM_STORE;
      end
      S_RCHK: begin
        w.load_cnt = 1'b1;
        w.jmp      = J_CHECK;
      end
      S_REMPTY: w.emit = EM_EMPTY;
      S_RZERO:  w.emit = EM_ZERO;
      S_RFIRST: begin
        w.rd  = RD_ALWAYS;
        w.tgt = S_RLOOP;
      end
      S_RLOOP: begin
        w.emit = EM_BYTE;
        w.rd   = RD_IF_MORE;
        w.jmp  = J_LOOP;
        w.tgt  = S_RLOOP;
      end
      default: w.tgt = S_IDLE;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/frb_seq.sv
// ----------------------------------------------------------------------------
// frb_seq
// step counter and control store of the ring buffer sequencer
// ----------------------------------------------------------------------------
module frb_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  frb_pkg::cond_t cond,
  output frb_pkg::ctl_t  ctl
);
  import frb_pkg::*;

  step_t step_r;
  step_t step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctl = ucode(step_r);
    case (ctl.jmp)
      J_GOTO:     step_nxt = ctl.tgt;
      J_DISPATCH: step_nxt = !cond.start ? S_IDLE : (cond.func ? S_RCHK : S_STORE);
      J_CHECK:    step_nxt = cond.empty ? S_REMPTY : (cond.zlen ? S_RZERO : S_RFIRST);
      J_LOOP:     step_nxt = cond.more ? ctl.tgt : S_IDLE;
      default:    step_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/core/framed_receive_ring_buffer.sv
// ----------------------------------------------------------------------------
// framed_receive_ring_buffer
// receive ring buffer with length-framed message detection
// ----------------------------------------------------------------------------
// usage
//   input words are commands: start is taken at an edge where busy is low.
//   in_func 0 stores in_rx_byte at the write pointer and runs the framing
//   tracker (header byte, count byte, then count payload bytes); in_func 1
//   pops in_read_len bytes (capped at 64) from the read pointer.
//   results come out on out_* ports for one cycle each, flagged by out_valid;
//   the receiver takes every result and cannot stall the block.
// sequence
//   a store runs the step S_STORE, with busy high, and gives a single
//   result; a read on an empty buffer or with length zero runs S_RCHK, then
//   S_REMPTY or S_RZERO. a read of n bytes runs S_RCHK, S_RFIRST, then
//   S_RLOOP once per byte, and puts out one byte per cycle; the rate is set
//   by the single read port of the byte memory and the step counter of the
//   sequencer.
// reset
//   synchronous, active low: pointers, framing tracker, notify enable and the
//   per-entry valid bits clear at once, so every entry reads as zero; no
//   clearing pass over the memory is needed.
// config
//   cfg_we/cfg_wdata write notify_enable; write it only while busy is low.
// ----------------------------------------------------------------------------
module framed_receive_ring_buffer #(
  parameter int BUFFER_DEPTH = frb_pkg::BufferDepth
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_func,
  input  logic [7:0]               in_rx_byte,
  input  logic [frb_pkg::LenW-1:0] in_read_len,
  // result channel
  output logic                     out_valid,
  output logic [7:0]               out_byte,
  output logic                     out_byte_valid,
  output logic                     out_frame_done,
  output logic [1:0]               out_read_status,
  output logic                     out_last,
  // configuration
  input  logic                     cfg_we,
  input  logic                     cfg_wdata
);
  import frb_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // pointer advance with wrap at the depth
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    if (p == AW'(BUFFER_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + AW'(1);
    end
    return q;
  endfunction

  ctl_t  ctl;
  cond_t cond;

  // captured command word
  logic [7:0]      byte_r;
  logic [LenW-1:0] len_r;

  // buffer state
  logic [7:0]              mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] vld_r;
  logic [AW-1:0]           wr_r;
  logic [AW-1:0]           rd_r;
  logic [7:0]              mem_q_r;
  logic                    vld_q_r;
  logic [LenW-1:0]         cnt_r;

  // framing tracker
  phase_t     phase_r, phase_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic       done;
  logic       notify_r;

  logic accept;
  logic issue;
  logic last_byte;

  // output registers
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_bv_r;
  logic       out_fd_r;
  rd_status_t out_st_r;
  logic       out_last_r;

  frb_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .cond (cond),
    .ctl  (ctl)
  );

  assign busy   = ctl.busy;
  assign accept = start && !ctl.busy;

  assign cond.start = start;
  assign cond.func  = in_func;
  assign cond.empty = (rd_r == wr_r);
  assign cond.zlen  = (len_r == '0);
  assign cond.more  = (cnt_r != '0);

  assign issue = (ctl.rd == RD_ALWAYS) || ((ctl.rd == RD_IF_MORE) && (cnt_r != '0));
  // no more reads queued means the byte now in hand is the final one
  assign last_byte = (cnt_r == '0);

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
      len_r  <= in_read_len;
    end
  end

  // byte memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.store) begin
      mem[wr_r] <= byte_r;
    end
    if (issue) begin
      mem_q_r <= mem[rd_r];
    end
  end

  // framing tracker next state
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    done      = 1'b0;
    if (ctl.store) begin
      case (phase_r)
        PH_HEADER: begin
          phase_nxt = PH_COUNT;
          rem_nxt   = byte_r;
        end
        PH_COUNT: begin
          // a count of zero wraps to a 256-byte frame
          rem_nxt = rem_r - 8'd1;
          if (rem_nxt == 8'd0) begin
            phase_nxt = PH_IDLE;
            done      = notify_r;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // pointers, valid bits, counter, tracker, config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      wr_r     <= '0;
      rd_r     <= '0;
      cnt_r    <= '0;
      phase_r  <= PH_IDLE;
      rem_r    <= '0;
      notify_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        notify_r <= cfg_wdata;
      end
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      if (ctl.store) begin
        vld_r[wr_r] <= 1'b1;
        wr_r        <= adv(wr_r);
      end
      if (ctl.load_cnt) begin
        cnt_r <= (len_r > LenW'(MaxPop)) ? LenW'(MaxPop) : len_r;
      end else if (issue) begin
        cnt_r <= cnt_r - LenW'(1);
      end
      if (issue) begin
        // popping clears the entry
        vld_r[rd_r] <= 1'b0;
        rd_r        <= adv(rd_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      vld_q_r <= vld_r[rd_r];
    end
  end

  // result formatting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctl.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= 8'd0;
    out_bv_r   <= 1'b0;
    out_fd_r   <= 1'b0;
    out_st_r   <= ST_REMAIN;
    out_last_r <= 1'b1;
    case (ctl.emit)
      EM_STORE: out_fd_r <= done;
      EM_EMPTY: out_st_r <= ST_WAS_EMPTY;
      EM_ZERO:  out_st_r <= ST_REMAIN;
      EM_BYTE: begin
        out_byte_r <= vld_q_r ? mem_q_r : 8'd0;
        out_bv_r   <= 1'b1;
        out_last_r <= last_byte;
        if (last_byte && (rd_r == wr_r)) begin
          out_st_r <= ST_NOW_EMPTY;
        end
      end
      default: out_last_r <= 1'b0;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = out_bv_r;
  assign out_frame_done  = out_fd_r;
  assign out_read_status = out_st_r;
  assign out_last        = out_last_r;

endmodule

### rtl/core/frb_checker.sv
// ----------------------------------------------------------------------------
// frb_checker
// port-level checks of the framed receive ring buffer
// ----------------------------------------------------------------------------
module frb_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     in_func,
  input logic                     out_valid,
  input logic                     out_byte_valid,
  input logic                     out_frame_done,
  input logic [1:0]               out_read_status,
  input logic                     out_last
);
  import frb_pkg::*;

  // ready for a command right after reset
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  // a store gives its one status-only result through the step and output registers
  a_store_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_func) |=> ##1 (out_valid && out_last && !out_byte_valid))
    else $error("store result missing");

  // bytes of a read come in an unbroken run
  a_byte_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap in popped bytes");

  // only the final result carries a status, only bytes are non-final
  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_byte_valid && out_read_status == ST_REMAIN))
    else $error("bad non-final result");

  // frame completion is flagged only on a store result
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_last && !out_byte_valid &&
                                       out_read_status == ST_REMAIN))
    else $error("frame_done on a read result");

endmodule

bind framed_receive_ring_buffer frb_checker u_frb_checker (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the framed receive ring buffer: a short table of
// hand-picked words, then random framed traffic with interleaved reads, each
// result word compared with a typed table word or a model of the ring and tracker
// ----------------------------------------------------------------------------
module tb;
  import frb_pkg::*;

  localparam int   PtrW       = $clog2(BufferDepth);
  localparam int   CycleLimit = 600000;
  localparam int   PhaseWords = 87;
  localparam logic FN_STORE   = 1'b0;
  localparam logic FN_READ    = 1'b1;

  typedef enum logic [1:0] {
    ROW_STORE  = 2'd0,
    ROW_READ   = 2'd1,
    ROW_NOTIFY = 2'd2
  } row_kind_t;

  // one result word as the block should put it out
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       frame_done;
    rd_status_t status;
    logic       last;
  } out_rec_t;

  // one stimulus row; typed rows carry their single result word
  typedef struct packed {
    row_kind_t       kind;
    logic [7:0]      rx;
    logic [LenW-1:0] len;
    logic            typed;
    logic            done;
    rd_status_t      status;
  } row_t;

  logic            clk         = 1'b0;
  logic            rst_n       = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  logic            in_func     = 1'b0;
  logic [7:0]      in_rx_byte  = '0;
  logic [LenW-1:0] in_read_len = '0;
  logic            out_valid;
  logic [7:0]      out_byte;
  logic            out_byte_valid;
  logic            out_frame_done;
  logic [1:0]      out_read_status;
  logic            out_last;
  logic            cfg_we      = 1'b0;
  logic            cfg_wdata   = 1'b0;

  // shadow of the ring, its pointers and the frame tracker
  logic [7:0]      ring_mem [BufferDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  phase_t          frame_ph;
  logic [7:0]      payload_left;
  logic            notify;

  out_rec_t    ring_results[$];
  out_rec_t    expected_words[$];
  out_rec_t    seen_exp;
  row_t        plan[$];
  logic        gaps_on = 1'b1;
  int          n_errors, n_results, n_frames, n_empty, n_stores, n_reads;
  int unsigned cycles;

  framed_receive_ring_buffer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_rx_byte      (in_rx_byte),
    .in_read_len     (in_read_len),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_frame_done  (out_frame_done),
    .out_read_status (out_read_status),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic out_rec_t word_rec(input logic [7:0] data, input logic bv,
                                        input logic fd, input rd_status_t st,
                                        input logic last);
    out_rec_t r;
    r.data       = data;
    r.byte_valid = bv;
    r.frame_done = fd;
    r.status     = st;
    r.last       = last;
    return r;
  endfunction

  function automatic row_t row(input row_kind_t kind, input logic [7:0] rx,
                               input logic [LenW-1:0] len, input logic typed,
                               input logic done, input rd_status_t status);
    row_t w;
    w.kind   = kind;
    w.rx     = rx;
    w.len    = len;
    w.typed  = typed;
    w.done   = done;
    w.status = status;
    return w;
  endfunction

  // mostly back-to-back, some short holes, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 30) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // advance the shadow ring by one command word, leaving its results in
  // ring_results
  task automatic ring_step(input row_t w);
    logic       fd;
    logic [7:0] b;
    rd_status_t st;
    int         n;
    int         i;
    ring_results.delete();
    if (w.kind == ROW_STORE) begin
      fd = 1'b0;
      ring_mem[wr_ptr] = w.rx;
      wr_ptr = wr_ptr + PtrW'(1);
      case (frame_ph)
        PH_HEADER: begin
          frame_ph     = PH_COUNT;
          payload_left = w.rx;
        end
        PH_COUNT: begin
          // a count of zero wraps, so such a frame runs 256 bytes
          payload_left = payload_left - 8'd1;
          if (payload_left == 8'd0) begin
            frame_ph = PH_IDLE;
            fd       = notify;
          end
        end
        default: frame_ph = PH_HEADER;
      endcase
      ring_results.push_back(word_rec(8'd0, 1'b0, fd, ST_REMAIN, 1'b1));
    end else if (rd_ptr == wr_ptr) begin
      ring_results.push_back(word_rec(8'd0, 1'b0, 1'b0, ST_WAS_EMPTY, 1'b1));
    end else begin
      n = (int'(w.len) > MaxPop) ? MaxPop : int'(w.len);
      if (n == 0) ring_results.push_back(word_rec(8'd0, 1'b0, 1'b0, ST_REMAIN, 1'b1));
      // pops run past the write pointer unchecked; status is judged at the end
      for (i = 0; i < n; i++) begin
        b = ring_mem[rd_ptr];
        ring_mem[rd_ptr] = 8'd0;
        rd_ptr = rd_ptr + PtrW'(1);
        if (i == n - 1) begin
          if (rd_ptr == wr_ptr) st = ST_NOW_EMPTY;
          else st = ST_REMAIN;
          ring_results.push_back(word_rec(b, 1'b1, 1'b0, st, 1'b1));
        end else begin
          ring_results.push_back(word_rec(b, 1'b1, 1'b0, ST_REMAIN, 1'b0));
        end
      end
    end
  endtask

  // hand one command word over and queue what it should produce
  task automatic issue(input row_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_func     <= (w.kind == ROW_READ) ? FN_READ : FN_STORE;
    in_rx_byte  <= w.rx;
    in_read_len <= w.len;
    do @(posedge clk); while (busy !== 1'b0);
    ring_step(w);
    if (w.typed) begin
      expected_words.push_back(word_rec(8'd0, 1'b0, w.done, w.status, 1'b1));
    end else begin
      foreach (ring_results[k]) expected_words.push_back(ring_results[k]);
    end
    if (w.kind == ROW_READ) n_reads++;
    else n_stores++;
  endtask

  // notify enable only changes while the block is idle and drained
  task automatic set_notify(input logic v);
    start <= 1'b0;
    while (expected_words.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    notify = v;
  endtask

  // result checker: every strobed word is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("result word byte %02h with nothing expected", out_byte));
      end else begin
        seen_exp = expected_words.pop_front();
        n_results++;
        if (seen_exp.frame_done) n_frames++;
        if (seen_exp.status == ST_WAS_EMPTY) n_empty++;
        if (out_byte !== seen_exp.data || out_byte_valid !== seen_exp.byte_valid ||
            out_frame_done !== seen_exp.frame_done ||
            out_read_status !== seen_exp.status || out_last !== seen_exp.last)
          flag_mismatch($sformatf(
            "word %0d got byte %02h bv %0b fd %0b st %0d last %0b, want %02h %0b %0b %0d %0b",
            n_results, out_byte, out_byte_valid, out_frame_done, out_read_status,
            out_last, seen_exp.data, seen_exp.byte_valid, seen_exp.frame_done,
            seen_exp.status, seen_exp.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_words.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int              ph;
    int              ph_words;
    int              sel;
    int              r;
    logic [7:0]      b;
    logic [LenW-1:0] len;
    logic [PtrW-1:0] avail;

    for (int i = 0; i < BufferDepth; i++) ring_mem[i] = 8'd0;
    wr_ptr       = '0;
    rd_ptr       = '0;
    frame_ph     = PH_IDLE;
    payload_left = 8'd0;
    notify       = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    plan.push_back(row(ROW_READ,   8'h3C, 7'd5,   1'b1, 1'b0, ST_WAS_EMPTY)); // empty after reset
    plan.push_back(row(ROW_READ,   8'h00, 7'd0,   1'b1, 1'b0, ST_WAS_EMPTY)); // zero length, empty
    plan.push_back(row(ROW_NOTIFY, 8'h01, 7'd0,   1'b0, 1'b0, ST_REMAIN));
    plan.push_back(row(ROW_STORE,  8'h00, 7'd0,   1'b1, 1'b0, ST_REMAIN));    // header
    plan.push_back(row(ROW_STORE,  8'h02, 7'd127, 1'b1, 1'b0, ST_REMAIN));    // count 2
    plan.push_back(row(ROW_STORE,  8'hFF, 7'd0,   1'b1, 1'b0, ST_REMAIN));
    plan.push_back(row(ROW_STORE,  8'hA5, 7'd0,   1'b1, 1'b1, ST_REMAIN));    // frame ends
    plan.push_back(row(ROW_READ,   8'hFF, 7'd0,   1'b1, 1'b0, ST_REMAIN));    // zero length
    plan.push_back(row(ROW_READ,   8'h00, 7'd2,   1'b0, 1'b0, ST_REMAIN));
    plan.push_back(row(ROW_READ,   8'h00, 7'd2,   1'b0, 1'b0, ST_REMAIN));    // drains ring
    plan.push_back(row(ROW_READ,   8'h00, 7'd3,   1'b1, 1'b0, ST_WAS_EMPTY));
    plan.push_back(row(ROW_NOTIFY, 8'h00, 7'd0,   1'b0, 1'b0, ST_REMAIN));
    plan.push_back(row(ROW_STORE,  8'h5A, 7'd64,  1'b1, 1'b0, ST_REMAIN));    // header
    plan.push_back(row(ROW_STORE,  8'h01, 7'd0,   1'b1, 1'b0, ST_REMAIN));    // count 1
    plan.push_back(row(ROW_STORE,  8'h80, 7'd0,   1'b1, 1'b0, ST_REMAIN));    // ends, quiet
    plan.push_back(row(ROW_READ,   8'h00, 7'd127, 1'b0, 1'b0, ST_REMAIN));    // oversized
    plan.push_back(row(ROW_READ,   8'h00, 7'd65,  1'b0, 1'b0, ST_REMAIN));
    plan.push_back(row(ROW_READ,   8'h00, 7'd64,  1'b0, 1'b0, ST_REMAIN));
    plan.push_back(row(ROW_READ,   8'h00, 7'd1,   1'b0, 1'b0, ST_REMAIN));
    plan.push_back(row(ROW_STORE,  8'h7F, 7'd0,   1'b1, 1'b0, ST_REMAIN));    // header

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_NOTIFY) set_notify(plan[k].rx[0]);
      else issue(plan[k]);
    end

    // random part: three phases, notify on, off, on, the middle one with no idle gaps
    for (ph = 0; ph < 3; ph++) begin
      set_notify(ph != 1);
      gaps_on  = (ph != 1);
      ph_words = 0;
      while (ph_words < PhaseWords) begin
        sel   = $urandom_range(0, 99);
        avail = wr_ptr - rd_ptr;
        len   = LenW'($urandom_range(0, 127));
        b     = 8'($urandom_range(0, 255));
        if (sel < 65) begin
          // framed byte: header, count or payload as the tracker stands
          if (frame_ph == PH_HEADER) begin
            r = $urandom_range(0, 99);
            if (r < 75) b = 8'($urandom_range(1, 6));
            else if (r < 95) b = 8'($urandom_range(7, 24));
            else b = 8'($urandom_range(25, 60));
          end
          issue(row(ROW_STORE, b, len, 1'b0, 1'b0, ST_REMAIN));
        end else if (sel < 92) begin
          // read sized to what is buffered, short of it, or anything
          r = $urandom_range(0, 99);
          if (r < 40) len = LenW'(avail);
          else if (r < 80) len = LenW'($urandom_range(0, int'(avail)));
          issue(row(ROW_READ, b, len, 1'b0, 1'b0, ST_REMAIN));
        end else begin
          // noise: any word with any fields
          issue(row(($urandom_range(0, 1) == 1) ? ROW_READ : ROW_STORE, b, len,
                    1'b0, 1'b0, ST_REMAIN));
        end
        ph_words++;
      end
    end

    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d stores and %0d reads gave %0d result words", n_stores, n_reads,
             n_results);
    $display("%0d frames flagged done, %0d reads found the ring empty, %0d mismatches",
             n_frames, n_empty, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/frb_pkg.sv
rtl/core/frb_seq.sv
rtl/core/framed_receive_ring_buffer.sv
rtl/core/frb_checker.sv
dv/tb.sv
